@@ sv/shacr_pkg.sv @@
// shared types, constants and tables of the sha-256 compression round core
package shacr_pkg;

   localparam int WORD_BITS        = 32;
   localparam int DIGEST_WORDS     = 8;
   localparam int INDEX_BITS       = $clog2(DIGEST_WORDS);
   localparam int ROUNDS_PER_BLOCK = 64;
   localparam int ROUND_BITS       = $clog2(ROUNDS_PER_BLOCK);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [ROUND_BITS-1:0] round_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef word_type words_type [DIGEST_WORDS];

   localparam round_type LAST_ROUND = round_type'(ROUNDS_PER_BLOCK - 1);
   localparam index_type LAST_INDEX = index_type'(DIGEST_WORDS - 1);

   typedef struct packed {
      logic [31:0] schedule_word;
      logic        message_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  digest_index;
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   localparam words_type INIT_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS_PER_BLOCK] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

@@ sv/shacr_round.sv @@
// one sha-256 compression round on the eight working words
module shacr_round
   import shacr_pkg::*;
(
   input  words_type work_cur,
   input  word_type  sched_word,
   input  word_type  round_const,
   output words_type work_nxt
);

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_BITS - n));
   endfunction

   word_type big_s1;
   word_type big_s0;
   word_type choose;
   word_type major;
   word_type t1;
   word_type t2;

   always_comb begin
      big_s1 = rotr(work_cur[4], 6) ^ rotr(work_cur[4], 11) ^ rotr(work_cur[4], 25);
      big_s0 = rotr(work_cur[0], 2) ^ rotr(work_cur[0], 13) ^ rotr(work_cur[0], 22);
      choose = (work_cur[4] & work_cur[5]) ^ (~work_cur[4] & work_cur[6]);
      major  = (work_cur[0] & work_cur[1]) ^ (work_cur[0] & work_cur[2])
             ^ (work_cur[1] & work_cur[2]);
      t1 = work_cur[7] + big_s1 + choose + round_const + sched_word;
      t2 = big_s0 + major;

      work_nxt[7] = work_cur[6];
      work_nxt[6] = work_cur[5];
      work_nxt[5] = work_cur[4];
      work_nxt[4] = work_cur[3] + t1;
      work_nxt[3] = work_cur[2];
      work_nxt[2] = work_cur[1];
      work_nxt[1] = work_cur[0];
      work_nxt[0] = t1 + t2;
   end

endmodule

@@ sv/shacr_digest_buf.sv @@
// digest hold buffer that sends the eight chaining words one per transaction
module shacr_digest_buf
   import shacr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  words_type load_words,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   words_type dig_ff;
   words_type dig_in;
   index_type cnt_ff;
   index_type cnt_in;
   logic      busy_ff;
   logic      busy_in;
   logic      take;

   assign take = busy_ff && !rsp_stall;

   always_comb begin
      dig_in  = dig_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (load) begin
         dig_in  = load_words;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (take) begin
         // shift so the word to send always sits in slot zero
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         cnt_in = cnt_ff + index_type'(1);
         if (cnt_ff == LAST_INDEX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   assign rsp_valid                = busy_ff;
   assign rsp_payload.digest_index = cnt_ff;
   assign rsp_payload.digest_word  = dig_ff[0];
   assign rsp_payload.digest_last  = (cnt_ff == LAST_INDEX);

endmodule

@@ sv/sha256_compression_rounds_core.sv @@
// sha-256 compression round core, one round per request transaction
//
// each request carries one expanded schedule word; the core applies one round
// per cycle to the working words, so requests can arrive each cycle while
// req_stall is low. message_start reloads the initial hash values before
// that round and makes it round 0 of a new message, dropping any partial
// block. after the 64th round the working words are added into the chaining
// value in the same cycle, and the eight chaining words go out on the
// response channel starting the cycle after that request, one word per cycle
// while rsp_stall is low, index 0 first, digest_last on index 7. throughput
// is one request per cycle unless req_stall is raised.
// the digest sits in a hold buffer, so requests of the next block keep
// flowing while the words drain. only if the buffer is still full while the
// round count stands at the final round is req_stall raised, until the last
// word has been taken; a long rsp_stall therefore backs up into the requests.
// synchronous reset loads the initial hash values, clears the round count
// and empties the hold buffer.
module sha256_compression_rounds_core
   import shacr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   words_type work_ff;
   words_type work_in;
   words_type chain_ff;
   words_type chain_in;
   round_type round_ff;
   round_type round_in;

   words_type work_eff;
   words_type chain_eff;
   round_type round_eff;
   words_type work_rnd;
   words_type block_sum;
   logic      accept;
   logic      done;

   assign req_stall = rsp_valid && (round_ff == LAST_ROUND);
   assign accept    = req_valid && !req_stall;

   // a start flag restarts from the initial values before the round
   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         work_eff[i]  = req_payload.message_start ? INIT_HASH[i] : work_ff[i];
         chain_eff[i] = req_payload.message_start ? INIT_HASH[i] : chain_ff[i];
      end
   end
   assign round_eff = req_payload.message_start ? '0 : round_ff;
   assign done      = accept && (round_eff == LAST_ROUND);

   shacr_round u_round (
      .work_cur    (work_eff),
      .sched_word  (req_payload.schedule_word),
      .round_const (ROUND_K[round_eff]),
      .work_nxt    (work_rnd)
   );

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         block_sum[i] = chain_eff[i] + work_rnd[i];
      end
   end

   always_comb begin
      work_in  = work_ff;
      chain_in = chain_ff;
      round_in = round_ff;
      if (accept) begin
         if (done) begin
            work_in  = block_sum;
            chain_in = block_sum;
            round_in = '0;
         end else begin
            work_in  = work_rnd;
            chain_in = chain_eff;
            round_in = round_eff + round_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= INIT_HASH;
         chain_ff <= INIT_HASH;
         round_ff <= '0;
      end else begin
         work_ff  <= work_in;
         chain_ff <= chain_in;
         round_ff <= round_in;
      end
   end

   shacr_digest_buf u_digest_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (done),
      .load_words  (block_sum),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a finished block shows up as word 0 of a digest in the next cycle
   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid && (rsp_payload.digest_index == '0))
      else $error("finished block did not start a digest");

   // a block can only finish while the hold buffer is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid)
      else $error("digest loaded over a pending digest");

   // words of one digest go out in index order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.digest_last |=>
         rsp_valid && (rsp_payload.digest_index == $past(rsp_payload.digest_index) + 3'd1))
      else $error("digest index skipped");

   // after the last word the buffer is empty
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.digest_last |=> !rsp_valid)
      else $error("response valid after last digest word");

   // a round inside a block advances the round count by one
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.message_start && (round_ff != LAST_ROUND) |=>
         round_ff == $past(round_ff) + 6'd1)
      else $error("round count did not advance");

endmodule

@@ dv/sha256_compression_rounds_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the sha-256 compression round core
module sha256_compression_rounds_core_tb;
   import shacr_pkg::*;

   localparam int unsigned STUCK_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned TOTAL_ITEMS   = 410;
   localparam int unsigned PRESSURE_RUNS = 2 * ROUNDS_PER_BLOCK;
   localparam int unsigned PHASE1_END    = 200;
   localparam int unsigned PHASE2_END    = TOTAL_ITEMS - PRESSURE_RUNS;

   typedef struct {
      word_type    first_word;
      word_type    stride;
      logic        start_first;
      int unsigned rounds;
   } round_run_type;

   // each row is a run of rounds: word i is first_word + i * stride
   localparam int DIRECTED_RUNS = 5;
   round_run_type directed_runs [DIRECTED_RUNS] = '{
      '{32'h00000000, 32'h00000000, 1'b0, 64},  // zero words right after reset, no flag
      '{32'h12345678, 32'h9e3779b9, 1'b1, 63},  // one round short of a digest
      '{32'hffffffff, 32'h00000000, 1'b1, 1},   // start lands on the final round slot
      '{32'ha5a5a5a5, 32'h00000000, 1'b1, 1},   // back-to-back starts
      '{32'hdeadbeef, 32'h11111111, 1'b0, 63}   // completes the block begun above
   };

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // predictor state
   word_type  work_words [DIGEST_WORDS];
   word_type  chain_words [DIGEST_WORDS];
   round_type round_count;
   rsp_type   expected_digest [$];

   int unsigned sender_gap_pct = 7;
   int unsigned recv_stall_pct = 85;
   int unsigned sent_items     = 0;
   int unsigned stuck_cycles   = 0;
   int unsigned error_count    = 0;
   logic        long_hold_pending = 1'b0;

   sha256_compression_rounds_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic word_type rotate_right(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_BITS - n));
   endfunction

   function automatic void reload_hash_state();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         work_words[i]  = INIT_HASH[i];
         chain_words[i] = INIT_HASH[i];
      end
      round_count = '0;
   endfunction

   // one compression round; the final round of a block queues the eight digest words
   function automatic void compress_round(input word_type w, input logic start);
      word_type sum1, sum0, choose, major, t1, t2;
      rsp_type  word_out;
      if (start) begin
         reload_hash_state();
      end
      sum1   = rotate_right(work_words[4], 6) ^ rotate_right(work_words[4], 11)
             ^ rotate_right(work_words[4], 25);
      choose = (work_words[4] & work_words[5]) ^ (~work_words[4] & work_words[6]);
      sum0   = rotate_right(work_words[0], 2) ^ rotate_right(work_words[0], 13)
             ^ rotate_right(work_words[0], 22);
      major  = (work_words[0] & work_words[1]) ^ (work_words[0] & work_words[2])
             ^ (work_words[1] & work_words[2]);
      t1 = work_words[7] + sum1 + choose + ROUND_K[round_count] + w;
      t2 = sum0 + major;
      for (int i = DIGEST_WORDS - 1; i > 0; i--) begin
         work_words[i] = work_words[i-1];
      end
      work_words[4] = work_words[4] + t1;
      work_words[0] = t1 + t2;
      if (round_count == LAST_ROUND) begin
         round_count = '0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_words[i] = chain_words[i] + work_words[i];
            work_words[i]  = chain_words[i];
            word_out.digest_index = index_type'(i);
            word_out.digest_word  = chain_words[i];
            word_out.digest_last  = (index_type'(i) == LAST_INDEX);
            expected_digest.push_back(word_out);
         end
      end else begin
         round_count = round_count + 1'b1;
      end
   endfunction

   // offer one round and hold it until the core takes it
   task automatic send_round(input word_type w, input logic start);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                 <= 1'b1;
      req_payload.schedule_word <= w;
      req_payload.message_start <= start;
      do @(posedge clock); while (req_stall);
      compress_round(w, start);
      sent_items++;
   endtask

   task automatic drain_digests();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_digest.size() != 0);
   endtask

   function automatic word_type random_word();
      case ($urandom_range(7))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   // mostly whole messages of one or two blocks; some aborted, unflagged or noisy
   task automatic send_message(input int unsigned budget);
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(9);
      len  = $urandom_range(1, 2) * ROUNDS_PER_BLOCK;
      case (kind)
         0: len = $urandom_range(1, ROUNDS_PER_BLOCK - 1);
         1: len = $urandom_range(1, 80);
         default: ;
      endcase
      if (len > budget) begin
         len = budget;
      end
      for (int unsigned i = 0; i < len; i++) begin
         if (kind == 1) begin
            send_round(random_word(), $urandom_range(15) == 0);
         end else begin
            send_round(random_word(), i == 0 && kind != 2);
         end
      end
   endtask

   // receiver side: random stall, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // digest word check against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digest.size() == 0) begin
            $error("unexpected digest transaction: index %0d word %08h",
                   rsp_payload.digest_index, rsp_payload.digest_word);
            error_count++;
         end else begin
            want = expected_digest.pop_front();
            if (rsp_payload.digest_index !== want.digest_index) begin
               $error("digest_index: expected %0d, got %0d",
                      want.digest_index, rsp_payload.digest_index);
               error_count++;
            end
            if (rsp_payload.digest_word !== want.digest_word) begin
               $error("digest_word: expected %08h, got %08h",
                      want.digest_word, rsp_payload.digest_word);
               error_count++;
            end
            if (rsp_payload.digest_last !== want.digest_last) begin
               $error("digest_last: expected %0b, got %0b",
                      want.digest_last, rsp_payload.digest_last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("sha256_compression_rounds_core_tb: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reload_hash_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_runs[r]) begin
         for (int unsigned i = 0; i < directed_runs[r].rounds; i++) begin
            send_round(directed_runs[r].first_word + word_type'(i) * directed_runs[r].stride,
                       directed_runs[r].start_first && i == 0);
         end
      end

      while (sent_items < PHASE1_END) send_message(PHASE1_END - sent_items);
      drain_digests();

      sender_gap_pct = 85;
      recv_stall_pct = 7;
      while (sent_items < PHASE2_END) send_message(PHASE2_END - sent_items);
      drain_digests();

      // receiver holds off while two full blocks stream in back to back
      sender_gap_pct    = 0;
      recv_stall_pct    = 0;
      long_hold_pending = 1'b1;
      for (int unsigned i = 0; i < PRESSURE_RUNS; i++) begin
         send_round($urandom(), i == 0);
      end

      drain_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("sha256_compression_rounds_core_tb: clean");
      end else begin
         $display("sha256_compression_rounds_core_tb: errors");
      end
      $finish;
   end

endmodule
